// File: rtl/core/fpexp_pkg.sv
// Shared types, constants and tables for the fixed-point exp block.
// Holds the inverse-factorial table and the microprogram ROM.
// No dependencies; compile first.
`default_nettype none

package fpexp_pkg;

    localparam int FRAC_BITS = 60;
    localparam int MAX_TERMS = 32;
    localparam int PREC_MAX  = 60;

    localparam int X_W   = 60;
    localparam int N_W   = 6;
    localparam int Y_W   = 62;
    localparam int B_W   = 6;
    localparam int P_W   = 6;
    localparam int MUL_W = 32;
    localparam int PP_W  = 2 * MUL_W;
    localparam int ACC_W = X_W + Y_W;
    localparam int INV_W = FRAC_BITS + 1;
    localparam int TBL_W = 63;

    typedef struct packed {
        logic [X_W-1:0] arg_value;
        logic [N_W-1:0] num_terms;
    } req_t;

    typedef struct packed {
        logic [Y_W-1:0] result_value;
        logic [B_W-1:0] error_bound;
        logic           bad_request;
    } rsp_t;

    typedef enum logic [1:0] {
        MUL_A0X0,
        MUL_A0X1,
        MUL_A1X0,
        MUL_A1X1
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD32,
        ACC_ADD64
    } acc_op_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_MORE,
        JMP_END
    } jmp_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    typedef logic [2:0] upc_t;

    localparam upc_t UPC_LOOP = 3'd0;
    localparam upc_t UPC_DONE = 3'd7;

    typedef struct packed {
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     shift_en;
        logic     add_en;
        logic     emit;
        jmp_t     jmp;
        upc_t     target;
    } ctrl_word_t;

    typedef struct packed {
        logic direct;
        logic more;
    } dp_status_t;

    localparam ctrl_word_t CTRL_NOP = '{
        mul_sel: MUL_A0X0, acc_op: ACC_HOLD, shift_en: 1'b0, add_en: 1'b0,
        emit: 1'b0, jmp: JMP_NEXT, target: UPC_LOOP};

    // One Horner step: four partial products into the accumulator,
    // then truncate, then add the coefficient; loop while terms remain.
    function automatic ctrl_word_t ucode_word(upc_t upc);
        ctrl_word_t w;
        w = CTRL_NOP;
        case (upc)
            3'd0: w.mul_sel = MUL_A0X0;
            3'd1:
            begin
                w.mul_sel = MUL_A0X1;
                w.acc_op  = ACC_LOAD;
            end
            3'd2:
            begin
                w.mul_sel = MUL_A1X0;
                w.acc_op  = ACC_ADD32;
            end
            3'd3:
            begin
                w.mul_sel = MUL_A1X1;
                w.acc_op  = ACC_ADD32;
            end
            3'd4: w.acc_op = ACC_ADD64;
            3'd5: w.shift_en = 1'b1;
            3'd6:
            begin
                w.add_en = 1'b1;
                w.jmp    = JMP_MORE;
                w.target = UPC_LOOP;
            end
            3'd7:
            begin
                w.emit = 1'b1;
                w.jmp  = JMP_END;
            end
            default: w = CTRL_NOP;
        endcase
        return w;
    endfunction

    // floor(2^62 / i!)
    function automatic logic [TBL_W-1:0] inv_fact62(logic [N_W-1:0] i);
        logic [TBL_W-1:0] v;
        case (i)
            6'd0:  v = 63'd4611686018427387904;
            6'd1:  v = 63'd4611686018427387904;
            6'd2:  v = 63'd2305843009213693952;
            6'd3:  v = 63'd768614336404564650;
            6'd4:  v = 63'd192153584101141162;
            6'd5:  v = 63'd38430716820228232;
            6'd6:  v = 63'd6405119470038038;
            6'd7:  v = 63'd915017067148291;
            6'd8:  v = 63'd114377133393536;
            6'd9:  v = 63'd12708570377059;
            6'd10: v = 63'd1270857037705;
            6'd11: v = 63'd115532457973;
            6'd12: v = 63'd9627704831;
            6'd13: v = 63'd740592679;
            6'd14: v = 63'd52899477;
            6'd15: v = 63'd3526631;
            6'd16: v = 63'd220414;
            6'd17: v = 63'd12965;
            6'd18: v = 63'd720;
            6'd19: v = 63'd37;
            6'd20: v = 63'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // floor(2^FRAC_BITS / i!)
    function automatic logic [INV_W-1:0] inv_fact_rom(logic [N_W-1:0] i);
        return INV_W'(inv_fact62(i) >> (TBL_W - 1 - FRAC_BITS));
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/fpexp_useq.sv
// Microcode sequencer: step counter, control-word ROM and jump logic.
// Depends on fpexp_pkg.
`default_nettype none

module fpexp_useq (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire fpexp_pkg::dp_status_t  status,
    output      logic                   busy,
    output      logic                   accept,
    output      fpexp_pkg::ctrl_word_t  ctrl
);
    import fpexp_pkg::*;

    seq_state_t state_reg, state_next;
    upc_t       upc_reg, upc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            upc_reg   <= UPC_LOOP;
        end
        else
        begin
            state_reg <= state_next;
            upc_reg   <= upc_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        upc_next   = upc_reg;
        ctrl       = CTRL_NOP;
        busy       = 1'b0;
        accept     = 1'b0;
        case (state_reg)
            SEQ_IDLE:
            begin
                accept = start;
                if (start)
                begin
                    state_next = SEQ_RUN;
                    // trivial requests skip straight to the emit step
                    upc_next   = status.direct ? UPC_DONE : UPC_LOOP;
                end
            end
            SEQ_RUN:
            begin
                busy = 1'b1;
                ctrl = ucode_word(upc_reg);
                case (ctrl.jmp)
                    JMP_NEXT: upc_next = upc_reg + 3'd1;
                    JMP_MORE: upc_next = status.more ? ctrl.target : upc_reg + 3'd1;
                    JMP_END:
                    begin
                        state_next = SEQ_IDLE;
                        upc_next   = UPC_LOOP;
                    end
                    default: upc_next = upc_reg + 3'd1;
                endcase
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/fpexp_dpath.sv
// Datapath: operand and sum registers, 32x32 partial-product multiplier,
// product accumulator, truncating shifter and coefficient adder.
// Depends on fpexp_pkg.
`default_nettype none

module fpexp_dpath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire fpexp_pkg::req_t        req,
    input  wire logic [5:0]             prec,
    input  wire fpexp_pkg::ctrl_word_t  ctrl,
    output      fpexp_pkg::dp_status_t  status,
    output      fpexp_pkg::rsp_t        rsp,
    output      logic                   done
);
    import fpexp_pkg::*;

    logic [X_W-1:0]   x_reg;
    logic [Y_W-1:0]   y_reg, y_next;
    logic [N_W-1:0]   idx_reg;
    logic             mode3_reg;
    logic [P_W-1:0]   shamt_reg;
    logic [B_W-1:0]   bound_reg, bound_next;
    logic             bad_reg;
    logic [PP_W-1:0]  pp_reg, pp_next;
    logic [ACC_W-1:0] acc_reg;
    logic [Y_W-1:0]   prod_reg;
    rsp_t             rsp_reg;
    logic             done_reg;

    logic [N_W-1:0]   n;
    logic [X_W-1:0]   x;
    logic             p_bad, n_bad, x_bad, bad;
    logic [P_W-1:0]   drop;
    logic [Y_W-1:0]   one_p;
    logic [N_W:0]     twice_n;
    logic [MUL_W-1:0] ma, mb;
    logic [Y_W-1:0]   addend;

    assign n     = req.num_terms;
    assign x     = req.arg_value;
    assign drop  = P_W'(FRAC_BITS) - prec;
    assign one_p = Y_W'(1) << prec;

    assign p_bad = (prec == '0) || (prec > P_W'(PREC_MAX)) || (prec > P_W'(FRAC_BITS));
    assign n_bad = (n == '0) || (9'(n) > 9'(MAX_TERMS));
    assign x_bad = (x >> prec) != '0;
    assign bad   = p_bad || n_bad || x_bad;

    assign status.direct = bad || (n < 6'd3);
    assign status.more   = idx_reg != '0;

    // starting sum and bound for each request class
    always_comb
    begin
        twice_n    = {n, 1'b0} - 7'd1;
        bound_next = '0;
        y_next     = Y_W'(inv_fact_rom(n - 6'd1) >> drop);
        if (bad)
            y_next = '0;
        else if (n == 6'd1)
            y_next = one_p;
        else if (n == 6'd2)
            y_next = one_p + Y_W'(x);
        else if (n == 6'd3)
        begin
            y_next     = Y_W'(x);
            bound_next = 6'd1;
        end
        else
            bound_next = twice_n[N_W] ? '1 : twice_n[B_W-1:0];
    end

    always_comb
    begin
        ma = y_reg[MUL_W-1:0];
        mb = x_reg[MUL_W-1:0];
        case (ctrl.mul_sel)
            MUL_A0X0: ;
            MUL_A0X1: mb = MUL_W'(x_reg[X_W-1:MUL_W]);
            MUL_A1X0: ma = MUL_W'(y_reg[Y_W-1:MUL_W]);
            MUL_A1X1:
            begin
                ma = MUL_W'(y_reg[Y_W-1:MUL_W]);
                mb = MUL_W'(x_reg[X_W-1:MUL_W]);
            end
            default: ;
        endcase
    end

    assign pp_next = ma * mb;

    assign addend = mode3_reg ? one_p + Y_W'(x_reg)
                              : Y_W'(inv_fact_rom(idx_reg) >> drop);

    always_ff @(posedge clk)
    begin
        pp_reg <= pp_next;
        if (accept)
        begin
            x_reg     <= x;
            y_reg     <= y_next;
            bound_reg <= bad ? '0 : bound_next;
            bad_reg   <= bad;
            mode3_reg <= (n == 6'd3);
            idx_reg   <= (n > 6'd3) ? n - 6'd2 : '0;
            shamt_reg <= (n == 6'd3) ? prec + 6'd1 : prec;
        end
        else if (ctrl.add_en)
        begin
            y_reg <= prod_reg + addend;
            if (status.more)
                idx_reg <= idx_reg - 6'd1;
        end
        case (ctrl.acc_op)
            ACC_HOLD:  ;
            ACC_LOAD:  acc_reg <= ACC_W'(pp_reg);
            ACC_ADD32: acc_reg <= acc_reg + (ACC_W'(pp_reg) << MUL_W);
            ACC_ADD64: acc_reg <= acc_reg + (ACC_W'(pp_reg) << (2 * MUL_W));
            default:   ;
        endcase
        if (ctrl.shift_en)
            prod_reg <= Y_W'(acc_reg >> shamt_reg);
        if (ctrl.emit)
        begin
            rsp_reg.result_value <= y_reg;
            rsp_reg.error_bound  <= bound_reg;
            rsp_reg.bad_request  <= bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctrl.emit;
    end

    assign rsp  = rsp_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// File: rtl/core/fixed_point_exp_taylor_horner.sv
// Top level of the fixed-point exp block: precision register, sequencer
// and datapath. Depends on fpexp_pkg, fpexp_useq, fpexp_dpath.
//
//  channel   ports                   beat taken when
//  -------   ---------------------   ------------------------------------
//  request   start, busy, req        start high and busy low at clk edge
//  result    done, rsp               done high (one cycle, no stall)
//  config    cfg_we, cfg_data        cfg_we high at clk edge
//
// Each Horner step runs four 32x32 partial products, the
// accumulate tail, the truncating shift and the coefficient add.
// Iterations: n-1 for n >= 4, one for n = 3, none for bad or n <= 2.
// busy is high while the sequencer runs, through the emit step; done is
// registered from the emit step and rises as busy falls.
// Reset sets precision to 60.
`default_nettype none

module fixed_point_exp_taylor_horner (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output      logic             busy,
    input  wire fpexp_pkg::req_t  req,
    output      logic             done,
    output      fpexp_pkg::rsp_t  rsp,
    input  wire logic             cfg_we,
    input  wire logic [5:0]       cfg_data
);
    import fpexp_pkg::*;

    logic [P_W-1:0] prec_reg;
    logic           accept;
    ctrl_word_t     ctrl;
    dp_status_t     status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prec_reg <= P_W'(PREC_MAX);
        else if (cfg_we)
            prec_reg <= cfg_data;
    end

    fpexp_useq u_useq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .accept (accept),
        .ctrl   (ctrl)
    );

    fpexp_dpath u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req),
        .prec   (prec_reg),
        .ctrl   (ctrl),
        .status (status),
        .rsp    (rsp),
        .done   (done)
    );

endmodule

`default_nettype wire

// File: rtl/core/fpexp_chk.sv
// Port-level checks for the fixed-point exp block, bound to the top level.
// Depends on fpexp_pkg and fixed_point_exp_taylor_horner.
`default_nettype none

module fpexp_chk (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             done,
    input wire fpexp_pkg::rsp_t  rsp
);

    // a beat taken must make the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request beat");

    // a result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without preceding work");

    // one beat per result, never back to back
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.bad_request) |->
            (rsp.result_value == '0) && (rsp.error_bound == '0))
        else $error("rejected request carries nonzero value or bound");

endmodule

bind fixed_point_exp_taylor_horner fpexp_chk u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for fixed_point_exp_taylor_horner: directed edge cases,
// random Taylor-series requests over several precision settings, and rejected requests.
// Depends on fpexp_pkg and the RTL top level; no other files.
`default_nettype none

module tb;
    import fpexp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    req_t       req;
    logic       done;
    rsp_t       rsp;
    logic       cfg_we;
    logic [5:0] cfg_data;

    rsp_t       expected_sums[$];
    logic [5:0] prec_shadow = 6'd60;
    int         mismatches = 0;
    int         stall_cycles = 0;
    bit         bursty = 1'b0;

    fixed_point_exp_taylor_horner dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor(2^FRAC_BITS / k!) by repeated integer division
    function automatic logic [63:0] inv_factorial(int k);
        logic [63:0] v;
        v = 64'd1 << FRAC_BITS;
        for (int j = 1; j <= k; j++)
            v = v / 64'(j);
        return v;
    endfunction

    function automatic rsp_t predict_exp(req_t r, logic [5:0] prec);
        rsp_t         o;
        logic [63:0]  x;
        logic [63:0]  y;
        logic [127:0] prod;
        int           n;
        int           p;
        int           bnd;
        o   = '0;
        x   = 64'(r.arg_value);
        n   = r.num_terms;
        p   = prec;
        bnd = 0;
        if (n == 0 || n > MAX_TERMS || p == 0 || p > PREC_MAX || p > FRAC_BITS
            || (x >> p) != 0)
        begin
            o.bad_request = 1'b1;
            return o;
        end
        if (n == 1)
            y = 64'd1 << p;
        else if (n == 2)
            y = (64'd1 << p) + x;
        else if (n == 3)
        begin
            prod = {64'd0, x} * {64'd0, x};
            y    = (64'd1 << p) + x + 64'(prod >> (p + 1));
            bnd  = 1;
        end
        else
        begin
            // Horner from the highest coefficient down, truncating each product
            y = inv_factorial(n - 1) >> (FRAC_BITS - p);
            for (int i = n - 2; i >= 0; i--)
            begin
                prod = {64'd0, y} * {64'd0, x};
                y    = 64'(prod >> p) + (inv_factorial(i) >> (FRAC_BITS - p));
            end
            bnd = 2 * n - 1;
            if (bnd > 63)
                bnd = 63;
        end
        o.result_value = y[Y_W-1:0];
        o.error_bound  = bnd[B_W-1:0];
        return o;
    endfunction

    task automatic report(string field, logic [63:0] want, logic [63:0] got);
        mismatches++;
        $display("%0t: %s expected %h actual %h", $time, field, want, got);
    endtask

    // Check each result beat, record each accepted request, track the register
    always @(posedge clk)
    begin : check_results
        rsp_t want;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (expected_sums.size() == 0)
                    report("unexpected result", '0, 64'(rsp));
                else
                begin
                    want = expected_sums.pop_front();
                    if (rsp.result_value !== want.result_value)
                        report("result_value", 64'(want.result_value), 64'(rsp.result_value));
                    if (rsp.error_bound !== want.error_bound)
                        report("error_bound", 64'(want.error_bound), 64'(rsp.error_bound));
                    if (rsp.bad_request !== want.bad_request)
                        report("bad_request", 64'(want.bad_request), 64'(rsp.bad_request));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                expected_sums.push_back(predict_exp(req, prec_shadow));
            if (cfg_we)
                prec_shadow = cfg_data;
            if (done === 1'b1 || (start === 1'b1 && busy === 1'b0) || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic issue_request(logic [X_W-1:0] arg, logic [N_W-1:0] terms);
        @(negedge clk);
        start <= 1'b1;
        req   <= '{arg_value: arg, num_terms: terms};
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // Mostly no gap, some short, a few long; none in burst phases
    task automatic pause_sender();
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (bursty || pick < 60)
            gap = 0;
        else if (pick < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(15, 60);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drop start and hold until every result is back, plus a short settle
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (expected_sums.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_precision(logic [5:0] value);
        wait_idle();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [X_W-1:0] pick_arg(int p);
        logic [63:0] r;
        logic [63:0] mask;
        int          pick;
        r    = {$urandom, $urandom};
        mask = (64'd1 << p) - 64'd1;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return X_W'(mask);
        else if (pick == 1)
            return X_W'(r & 64'hFF);
        else
            return X_W'(r & mask);
    endfunction

    task automatic test_reset_precision_edges();
        logic [X_W-1:0] xmax;
        xmax = '1;
        // precision still at its reset value
        issue_request('0, 6'd1);
        issue_request('0, 6'd2);
        issue_request('0, 6'd3);
        issue_request('0, 6'd4);
        issue_request(xmax, 6'd1);
        issue_request(xmax, 6'd2);
        issue_request(xmax, 6'd3);
        issue_request(xmax, 6'(MAX_TERMS));
        issue_request(xmax, 6'(MAX_TERMS - 1));
        issue_request(60'd1, 6'(MAX_TERMS));
        issue_request(xmax, 6'd0);
        issue_request(xmax, 6'(MAX_TERMS + 1));
        issue_request(xmax, 6'd63);
    endtask

    task automatic test_precision_extremes();
        set_precision(6'd1);
        issue_request(60'd1, 6'(MAX_TERMS));
        issue_request(60'd0, 6'd4);
        issue_request(60'd2, 6'd5);
        set_precision(6'd0);
        issue_request(60'd0, 6'd1);
        set_precision(6'd63);
        issue_request(60'd0, 6'd1);
        set_precision(6'd61);
        issue_request(60'd0, 6'd4);
        set_precision(6'd59);
        issue_request(60'd1 << 59, 6'd4);
        issue_request((60'd1 << 59) - 60'd1, 6'd20);
    endtask

    task automatic test_random_series(int per_phase);
        logic [5:0] phases[6];
        int         p;
        int         pick;
        logic [X_W-1:0] arg;
        logic [N_W-1:0] terms;
        phases = '{6'd60, 6'd1, 6'd2, 6'd59, 6'd33, 6'($urandom_range(3, 58))};
        foreach (phases[k])
        begin
            p      = phases[k];
            bursty = (k % 2) == 1;
            set_precision(phases[k]);
            for (int i = 0; i < per_phase; i++)
            begin
                pick  = $urandom_range(0, 19);
                arg   = pick_arg(p);
                terms = 6'($urandom_range(1, MAX_TERMS));
                // a little noise: out-of-range term count or argument not below one
                if (pick == 0)
                    terms = ($urandom_range(0, 1) == 0) ? 6'd0
                                                       : 6'($urandom_range(MAX_TERMS + 1, 63));
                else if (pick == 1 && p < X_W)
                    arg = arg | (X_W'(1) << p) | X_W'({$urandom, $urandom} << p);
                issue_request(arg, terms);
                if (i == per_phase / 2)
                    wait_idle();
                else
                    pause_sender();
            end
        end
        bursty = 1'b0;
    endtask

    task automatic test_rejected_requests(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 20 == 0)
                set_precision(6'($urandom_range(0, 63)));
            issue_request(X_W'({$urandom, $urandom}), 6'($urandom_range(0, 63)));
            pause_sender();
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        req      = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_precision_edges();
        test_precision_extremes();
        test_random_series(85);
        test_rejected_requests(80);

        wait_idle();
        repeat (20) @(posedge clk);
        if (expected_sums.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
